[sv/dhf_pkg.sv]
package dhf_pkg;

	localparam int DEPTH_W = 16;
	localparam int SUM_W   = 19;   // eight 16-bit neighbors
	localparam int CNT_W   = 4;    // 0..8 neighbors
	localparam int ROW_W   = 12;
	localparam int COL_W   = 10;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 13;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_VALID    = 2'd2;

	localparam logic [10:0] RST_FRAME_WIDTH  = 11'd640;
	localparam logic [12:0] RST_FRAME_HEIGHT = 13'd480;
	localparam logic [3:0]  RST_MIN_VALID    = 4'd4;

	typedef enum logic [1:0] {
		SEL_INTERIOR = 2'd0,
		SEL_RIGHT    = 2'd1,
		SEL_LASTROW  = 2'd2
	} res_sel_t;

	typedef struct packed {
		logic     accept;
		logic     shift;
		logic     div_start;
		logic     emit;
		res_sel_t sel;
		logic     last;
	} dhf_cmd_t;

	typedef struct packed {
		logic need_a;
		logic need_b;
		logic need_c;
		logic fill;
		logic div_busy;
		logic out_free;
	} dhf_sts_t;

endpackage

[sv/dhf_div.sv]
module dhf_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [dhf_pkg::SUM_W-1:0] dividend,
	input  logic [dhf_pkg::CNT_W-1:0] divisor,
	output logic                      busy,
	output logic [dhf_pkg::SUM_W-1:0] quotient
);

	localparam int STEP_W = $clog2(dhf_pkg::SUM_W + 1);

	logic                      busy_q;
	logic [STEP_W-1:0]         step_q;
	logic [dhf_pkg::SUM_W-1:0] dvd_q;
	logic [dhf_pkg::CNT_W-1:0] rem_q;
	logic [dhf_pkg::CNT_W-1:0] dsr_q;
	logic [dhf_pkg::CNT_W:0]   rem_sh;
	logic [dhf_pkg::CNT_W:0]   rem_sub;
	logic                      ge;

	// restoring division, one quotient bit per cycle, quotient shifts into dvd_q
	always_comb begin
		rem_sh  = {rem_q, dvd_q[dhf_pkg::SUM_W-1]};
		ge      = rem_sh >= {1'b0, dsr_q};
		rem_sub = rem_sh - {1'b0, dsr_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= STEP_W'(dhf_pkg::SUM_W);
		end else if (busy_q) begin
			step_q <= step_q - 1'b1;
			if (step_q == STEP_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[dhf_pkg::SUM_W-2:0], ge};
			rem_q <= ge ? rem_sub[dhf_pkg::CNT_W-1:0] : rem_sh[dhf_pkg::CNT_W-1:0];
		end
	end

	assign busy     = busy_q;
	assign quotient = dvd_q;

endmodule

[sv/dhf_datapath.sv]
module dhf_datapath #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  dhf_pkg::dhf_cmd_t              cmd,
	output dhf_pkg::dhf_sts_t              sts,
	input  logic                           cfg_we,
	input  logic [dhf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [dhf_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic [dhf_pkg::DEPTH_W-1:0]    depth_in,
	input  logic                           out_stall,
	output logic                           out_valid,
	output logic [dhf_pkg::ROW_W-1:0]      out_row,
	output logic [dhf_pkg::COL_W-1:0]      out_col,
	output logic [dhf_pkg::DEPTH_W-1:0]    depth_out,
	output logic                           was_filled,
	output logic                           last_of_run
);

	localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

	logic [10:0] width_q;
	logic [12:0] height_q;
	logic [3:0]  thr_q;

	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [CW-1:0] c_q;
	logic [RW-1:0] r_q;
	logic [dhf_pkg::DEPTH_W-1:0] x_q;

	logic [dhf_pkg::DEPTH_W-1:0] upper_mem [MAX_WIDTH];
	logic [dhf_pkg::DEPTH_W-1:0] lower_mem [MAX_WIDTH];
	logic [dhf_pkg::DEPTH_W-1:0] up_rd_q;
	logic [dhf_pkg::DEPTH_W-1:0] lo_rd_q;

	logic [dhf_pkg::DEPTH_W-1:0] win_q [9];
	logic fill_q;

	logic [31:0] w_full;
	logic [31:0] h_full;
	logic [CW-1:0] w_last;
	logic [RW-1:0] h_last;
	logic [CW-1:0] c_eff;
	logic [RW-1:0] r_eff;
	logic [3:0] thr_eff;

	logic [dhf_pkg::SUM_W-1:0] sum_c;
	logic [dhf_pkg::CNT_W-1:0] cnt_c;
	logic [dhf_pkg::SUM_W-1:0] quot;
	logic div_busy;

	logic                        out_valid_q;
	logic [dhf_pkg::ROW_W-1:0]   out_row_q;
	logic [dhf_pkg::COL_W-1:0]   out_col_q;
	logic [dhf_pkg::DEPTH_W-1:0] depth_out_q;
	logic                        was_filled_q;
	logic                        last_q;
	logic [RW-1:0] row_m1;
	logic [CW-1:0] col_m1;

	// geometry clamp
	always_comb begin
		if (32'(width_q) < 32'd3) begin
			w_full = 32'd3;
		end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
			w_full = 32'(MAX_WIDTH);
		end else begin
			w_full = 32'(width_q);
		end
		if (32'(height_q) < 32'd3) begin
			h_full = 32'd3;
		end else if (32'(height_q) > 32'(MAX_HEIGHT)) begin
			h_full = 32'(MAX_HEIGHT);
		end else begin
			h_full = 32'(height_q);
		end
		w_last  = CW'(w_full - 32'd1);
		h_last  = RW'(h_full - 32'd1);
		thr_eff = (thr_q == 4'd0) ? 4'd1 : thr_q;
		if (col_q > w_last || row_q > h_last) begin
			c_eff = '0;
			r_eff = '0;
		end else begin
			c_eff = col_q;
			r_eff = row_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= dhf_pkg::RST_FRAME_WIDTH;
			height_q <= dhf_pkg::RST_FRAME_HEIGHT;
			thr_q    <= dhf_pkg::RST_MIN_VALID;
			col_q    <= '0;
			row_q    <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				dhf_pkg::REG_FRAME_WIDTH: begin
					width_q <= cfg_data[10:0];
					col_q   <= '0;
					row_q   <= '0;
				end
				dhf_pkg::REG_FRAME_HEIGHT: begin
					height_q <= cfg_data[12:0];
					col_q    <= '0;
					row_q    <= '0;
				end
				dhf_pkg::REG_MIN_VALID: begin
					thr_q <= cfg_data[3:0];
				end
				default: begin
				end
			endcase
		end else if (cmd.shift) begin
			if (c_q == w_last) begin
				col_q <= '0;
				row_q <= (r_q == h_last) ? '0 : r_q + 1'b1;
			end else begin
				col_q <= c_q + 1'b1;
				row_q <= r_q;
			end
		end
	end

	// item latch and line store read
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			x_q     <= depth_in;
			c_q     <= c_eff;
			r_q     <= r_eff;
			up_rd_q <= upper_mem[c_eff];
			lo_rd_q <= lower_mem[c_eff];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.shift) begin
			upper_mem[c_q] <= lo_rd_q;
			lower_mem[c_q] <= x_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 9; i++) begin
				win_q[i] <= '0;
			end
		end else if (cmd.shift) begin
			for (int i = 0; i < 3; i++) begin
				win_q[i*3]   <= win_q[i*3+1];
				win_q[i*3+1] <= win_q[i*3+2];
			end
			win_q[2] <= up_rd_q;
			win_q[5] <= lo_rd_q;
			win_q[8] <= x_q;
		end
	end

	// neighbor sum and count of the nonzero cells among the eight around the center
	always_comb begin
		sum_c = '0;
		cnt_c = '0;
		for (int i = 0; i < 9; i++) begin
			if (i != 4 && win_q[i] != '0) begin
				sum_c = sum_c + dhf_pkg::SUM_W'(win_q[i]);
				cnt_c = cnt_c + 1'b1;
			end
		end
	end

	always_comb begin
		sts.need_a   = (r_q != '0) && (c_q != '0);
		sts.need_b   = (r_q != '0) && (c_q == w_last);
		sts.need_c   = (r_q == h_last);
		sts.fill     = (win_q[4] == '0) && (32'(r_q) >= 32'd2) && (32'(c_q) >= 32'd2)
			&& (cnt_c >= thr_eff) && (cnt_c != '0);
		sts.div_busy = div_busy;
		sts.out_free = !out_valid_q || !out_stall;
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start || cmd.shift) begin
			fill_q <= cmd.div_start;
		end
	end

	dhf_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (sum_c),
		.divisor  (cnt_c),
		.busy     (div_busy),
		.quotient (quot)
	);

	// output word register
	assign row_m1 = r_q - 1'b1;
	assign col_m1 = c_q - 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			last_q <= cmd.last;
			case (cmd.sel)
				dhf_pkg::SEL_INTERIOR: begin
					out_row_q    <= dhf_pkg::ROW_W'(32'(row_m1));
					out_col_q    <= dhf_pkg::COL_W'(32'(col_m1));
					depth_out_q  <= fill_q ? quot[dhf_pkg::DEPTH_W-1:0] : win_q[4];
					was_filled_q <= fill_q;
				end
				dhf_pkg::SEL_RIGHT: begin
					out_row_q    <= dhf_pkg::ROW_W'(32'(row_m1));
					out_col_q    <= dhf_pkg::COL_W'(32'(w_last));
					depth_out_q  <= win_q[5];
					was_filled_q <= 1'b0;
				end
				default: begin
					out_row_q    <= dhf_pkg::ROW_W'(32'(h_last));
					out_col_q    <= dhf_pkg::COL_W'(32'(c_q));
					depth_out_q  <= x_q;
					was_filled_q <= 1'b0;
				end
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign out_row     = out_row_q;
	assign out_col     = out_col_q;
	assign depth_out   = depth_out_q;
	assign was_filled  = was_filled_q;
	assign last_of_run = last_q;

endmodule

[sv/dhf_ctrl.sv]
module dhf_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  dhf_pkg::dhf_sts_t sts,
	output dhf_pkg::dhf_cmd_t cmd
);

	typedef enum logic [6:0] {
		ST_IDLE   = 7'b0000001,
		ST_READ   = 7'b0000010,
		ST_SUM    = 7'b0000100,
		ST_DIV    = 7'b0001000,
		ST_EMIT_A = 7'b0010000,
		ST_EMIT_B = 7'b0100000,
		ST_EMIT_C = 7'b1000000
	} state_t;

	state_t state_q;
	state_t state_d;
	state_t first_emit;
	state_t after_a;
	state_t after_b;

	always_comb begin
		if (sts.need_a) begin
			first_emit = ST_EMIT_A;
		end else if (sts.need_b) begin
			first_emit = ST_EMIT_B;
		end else if (sts.need_c) begin
			first_emit = ST_EMIT_C;
		end else begin
			first_emit = ST_IDLE;
		end
		if (sts.need_b) begin
			after_a = ST_EMIT_B;
		end else if (sts.need_c) begin
			after_a = ST_EMIT_C;
		end else begin
			after_a = ST_IDLE;
		end
		after_b = sts.need_c ? ST_EMIT_C : ST_IDLE;
	end

	always_comb begin
		state_d       = state_q;
		cmd           = '0;
		cmd.sel       = dhf_pkg::SEL_INTERIOR;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = ST_READ;
				end
			end
			ST_READ: begin
				cmd.shift = 1'b1;
				state_d   = ST_SUM;
			end
			ST_SUM: begin
				if (sts.fill) begin
					cmd.div_start = 1'b1;
					state_d       = ST_DIV;
				end else begin
					state_d = first_emit;
				end
			end
			ST_DIV: begin
				if (!sts.div_busy) begin
					state_d = first_emit;
				end
			end
			ST_EMIT_A: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					cmd.sel  = dhf_pkg::SEL_INTERIOR;
					cmd.last = (after_a == ST_IDLE);
					state_d  = after_a;
				end
			end
			ST_EMIT_B: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					cmd.sel  = dhf_pkg::SEL_RIGHT;
					cmd.last = (after_b == ST_IDLE);
					state_d  = after_b;
				end
			end
			ST_EMIT_C: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					cmd.sel  = dhf_pkg::SEL_LASTROW;
					cmd.last = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_stall = (state_q != ST_IDLE);

endmodule

[sv/depth_hole_fill_3x3.sv]
// channel   direction  handshake              payload
// in        sink       in_valid / in_stall    depth_in
// out       source     out_valid / out_stall  out_row, out_col, depth_out, was_filled,
//                                             last_of_run
// cfg       sink       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One word at a time: accept, line store read, window shift, neighbor sum, then an
// optional divide in the 19-step divider when a hole is filled, then each result word
// from its own emit state. Output stalls hold the emit states; a waiting result does
// not block the next input word. cfg_ready is always high.
// Reset clears control, counters, window and geometry registers; line stores keep
// whatever they hold; their contents reach a result only once written in this frame.
module depth_hole_fill_3x3 #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [dhf_pkg::DEPTH_W-1:0]    depth_in,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [dhf_pkg::ROW_W-1:0]      out_row,
	output logic [dhf_pkg::COL_W-1:0]      out_col,
	output logic [dhf_pkg::DEPTH_W-1:0]    depth_out,
	output logic                           was_filled,
	output logic                           last_of_run,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [dhf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [dhf_pkg::CFG_DATA_W-1:0] cfg_data
);

	dhf_pkg::dhf_cmd_t cmd;
	dhf_pkg::dhf_sts_t sts;

	assign cfg_ready = 1'b1;

	dhf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	dhf_datapath #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.cfg_we      (cfg_valid & cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.depth_in    (depth_in),
		.out_stall   (out_stall),
		.out_valid   (out_valid),
		.out_row     (out_row),
		.out_col     (out_col),
		.depth_out   (depth_out),
		.was_filled  (was_filled),
		.last_of_run (last_of_run)
	);

endmodule

[tb/depth_hole_fill_3x3_tb.sv]
`timescale 1ns / 1ps

module depth_hole_fill_3x3_tb;

	localparam int LINE_MAX   = 1024;
	localparam int ROWS_MAX   = 4096;
	localparam int SETTLE     = 40;      // extra wait in drain() after the last expected word
	localparam int CYCLE_CAP  = 1000000;
	localparam int REPORT_CAP = 200;
	localparam logic [dhf_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;   // no register behind it

	typedef struct packed {
		logic [dhf_pkg::ROW_W-1:0]   row;
		logic [dhf_pkg::COL_W-1:0]   col;
		logic [dhf_pkg::DEPTH_W-1:0] depth;
		logic                        filled;
		logic                        last;
	} pixel_word_t;

	class hole_fill_scoreboard;
		logic [10:0] frame_w;
		logic [12:0] frame_h;
		logic [3:0]  min_nb;
		logic [dhf_pkg::DEPTH_W-1:0] upper [LINE_MAX];
		logic [dhf_pkg::DEPTH_W-1:0] lower [LINE_MAX];
		logic [dhf_pkg::DEPTH_W-1:0] win [9];
		int unsigned col_pos;
		int unsigned row_pos;
		pixel_word_t pending_words [$];
		int errors;

		function new();
			frame_w = dhf_pkg::RST_FRAME_WIDTH;
			frame_h = dhf_pkg::RST_FRAME_HEIGHT;
			min_nb  = dhf_pkg::RST_MIN_VALID;
			foreach (upper[i]) begin
				upper[i] = '0;
				lower[i] = '0;
			end
			foreach (win[i]) win[i] = '0;
			col_pos = 0;
			row_pos = 0;
			errors  = 0;
		endfunction

		function int unsigned clamp(int unsigned v, int unsigned lo, int unsigned hi);
			return (v < lo) ? lo : ((v > hi) ? hi : v);
		endfunction

		function void note_config(logic [dhf_pkg::CFG_IDX_W-1:0] idx,
				logic [dhf_pkg::CFG_DATA_W-1:0] data);
			case (idx)
				dhf_pkg::REG_FRAME_WIDTH: begin
					frame_w = data[10:0];
					col_pos = 0;
					row_pos = 0;
				end
				dhf_pkg::REG_FRAME_HEIGHT: begin
					frame_h = data[12:0];
					col_pos = 0;
					row_pos = 0;
				end
				dhf_pkg::REG_MIN_VALID: min_nb = data[3:0];
				default: ;
			endcase
		endfunction

		function void note_input(logic [dhf_pkg::DEPTH_W-1:0] d);
			int unsigned w, h, t, r, c, sum, cnt, value;
			logic filled;
			logic [dhf_pkg::DEPTH_W-1:0] up, lo;
			pixel_word_t word;
			pixel_word_t run [$];
			w = clamp(32'(frame_w), 3, LINE_MAX);
			h = clamp(32'(frame_h), 3, ROWS_MAX);
			t = (min_nb == 0) ? 1 : 32'(min_nb);
			r = row_pos;
			c = col_pos;
			if (c >= w || r >= h) begin
				c = 0;
				r = 0;
			end
			up = upper[c];
			lo = lower[c];
			for (int i = 0; i < 3; i++) begin
				win[i*3]   = win[i*3+1];
				win[i*3+1] = win[i*3+2];
			end
			win[2] = up;
			win[5] = lo;
			win[8] = d;
			upper[c] = lo;
			lower[c] = d;

			if (r >= 1 && c >= 1) begin
				value  = 32'(win[4]);
				filled = 1'b0;
				if (win[4] == 0 && r >= 2 && c >= 2) begin
					sum = 0;
					cnt = 0;
					for (int i = 0; i < 9; i++) begin
						if (i != 4 && win[i] != 0) begin
							sum += 32'(win[i]);
							cnt++;
						end
					end
					if (cnt >= t && cnt != 0) begin
						value  = sum / cnt;
						filled = 1'b1;
					end
				end
				word = '{row: dhf_pkg::ROW_W'(r - 1), col: dhf_pkg::COL_W'(c - 1),
					depth: dhf_pkg::DEPTH_W'(value), filled: filled, last: 1'b0};
				run.push_back(word);
			end
			// right border of the row above goes out unchanged
			if (r >= 1 && c == w - 1) begin
				word = '{row: dhf_pkg::ROW_W'(r - 1), col: dhf_pkg::COL_W'(w - 1),
					depth: win[5], filled: 1'b0, last: 1'b0};
				run.push_back(word);
			end
			// last row is sent straight through
			if (r == h - 1) begin
				word = '{row: dhf_pkg::ROW_W'(h - 1), col: dhf_pkg::COL_W'(c),
					depth: d, filled: 1'b0, last: 1'b0};
				run.push_back(word);
			end
			if (run.size() > 0) run[run.size()-1].last = 1'b1;
			foreach (run[i]) pending_words.push_back(run[i]);

			c++;
			if (c >= w) begin
				c = 0;
				r++;
				if (r >= h) r = 0;
			end
			col_pos = c;
			row_pos = r;
		endfunction

		function void check_result(pixel_word_t got);
			pixel_word_t want;
			if (pending_words.size() == 0) begin
				errors++;
				if (errors <= REPORT_CAP)
					$display("%0t: expected no word, got row=%0d col=%0d depth=%0d %s",
						$time, got.row, got.col, got.depth,
						$sformatf("filled=%0b last=%0b", got.filled, got.last));
				return;
			end
			want = pending_words.pop_front();
			if (got !== want) begin
				errors++;
				if (errors <= REPORT_CAP)
					$display("%0t: expected %s, got %s", $time,
						$sformatf("row=%0d col=%0d depth=%0d filled=%0b last=%0b",
							want.row, want.col, want.depth, want.filled, want.last),
						$sformatf("row=%0d col=%0d depth=%0d filled=%0b last=%0b",
							got.row, got.col, got.depth, got.filled, got.last));
			end
		endfunction

		function int outstanding();
			return pending_words.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [dhf_pkg::DEPTH_W-1:0] depth_in = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [dhf_pkg::ROW_W-1:0] out_row;
	logic [dhf_pkg::COL_W-1:0] out_col;
	logic [dhf_pkg::DEPTH_W-1:0] depth_out;
	logic was_filled;
	logic last_of_run;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [dhf_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [dhf_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	hole_fill_scoreboard sb = new();
	bit idle_on = 1'b1;
	int cycles = 0;
	int stall_left = 0;

	depth_hole_fill_3x3 uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .depth_in(depth_in),
		.out_valid(out_valid), .out_stall(out_stall),
		.out_row(out_row), .out_col(out_col), .depth_out(depth_out),
		.was_filled(was_filled), .last_of_run(last_of_run),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_CAP) begin
			$display("depth_hole_fill_3x3: mismatch");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result('{row: out_row, col: out_col, depth: depth_out,
				filled: was_filled, last: last_of_run});
	end

	// receiver back-pressure in bursts
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else if (idle_on && $urandom_range(0, 4) == 0) begin
			stall_left = $urandom_range(1, 15) - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	function logic [dhf_pkg::DEPTH_W-1:0] pick_depth();
		int unsigned pick;
		pick = $urandom_range(0, 9);
		if (pick inside {[0:3]}) return '0;
		case (pick)
			4:       return '1;
			5:       return dhf_pkg::DEPTH_W'($urandom_range(1, 15));
			default: return dhf_pkg::DEPTH_W'($urandom);
		endcase
	endfunction

	task send_depth(input logic [dhf_pkg::DEPTH_W-1:0] d);
		in_valid <= 1'b1;
		depth_in <= d;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_input(d);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			depth_in <= dhf_pkg::DEPTH_W'($urandom);
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
	endtask

	// block must be quiet before any register write
	task drain();
		in_valid <= 1'b0;
		while (sb.outstanding() > 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task write_reg(input logic [dhf_pkg::CFG_IDX_W-1:0] idx,
			input logic [dhf_pkg::CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.note_config(idx, data);
		cfg_valid <= 1'b0;
		cfg_data  <= dhf_pkg::CFG_DATA_W'($urandom);
		@(posedge clk);
	endtask

	task run_phase(input logic [dhf_pkg::CFG_DATA_W-1:0] w,
			input logic [dhf_pkg::CFG_DATA_W-1:0] h,
			input logic [dhf_pkg::CFG_DATA_W-1:0] t, input int n);
		drain();
		write_reg(dhf_pkg::REG_FRAME_WIDTH, w);
		write_reg(dhf_pkg::REG_FRAME_HEIGHT, h);
		write_reg(dhf_pkg::REG_MIN_VALID, t);
		repeat (n) send_depth(pick_depth());
	endtask

	logic [dhf_pkg::DEPTH_W-1:0] directed [27] = '{
		// full ring around a hole
		16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
		// exactly four neighbors
		16'd5, 16'd0, 16'd7, 16'd0, 16'd0, 16'd0, 16'd1, 16'd2, 16'd0,
		// three neighbors, below threshold
		16'd5, 16'd0, 16'd7, 16'd0, 16'd0, 16'd0, 16'd1, 16'd0, 16'd0
	};

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset geometry: row 0 words give no result
		repeat (3) send_depth(pick_depth());
		drain();
		write_reg(dhf_pkg::REG_FRAME_WIDTH, 13'd3);
		write_reg(dhf_pkg::REG_FRAME_HEIGHT, 13'd3);
		foreach (directed[i]) send_depth(directed[i]);

		run_phase(13'd4, 13'd5, 13'd1, 24);
		run_phase(13'd0, 13'd0, 13'd0, 18);          // both clamp to 3, threshold 0 acts as 1
		run_phase(13'd5, 13'd4, 13'd8, 24);
		run_phase(13'd3, 13'd4096, 13'd2, 15);
		run_phase(13'd7, 13'd3, 13'd9, 18);          // threshold above 8 never fills
		run_phase(13'h1FFF, 13'h1FFF, 13'd15, 16);   // widest, tallest
		drain();
		write_reg(REG_SPARE, dhf_pkg::CFG_DATA_W'($urandom));
		run_phase(13'd6, 13'd6, 13'd3, 40);

		drain();
		idle_on = 1'b0;
		write_reg(dhf_pkg::REG_FRAME_WIDTH, 13'd3);
		write_reg(dhf_pkg::REG_FRAME_HEIGHT, 13'd3);
		write_reg(dhf_pkg::REG_MIN_VALID, 13'd4);
		repeat (30) send_depth(pick_depth());

		drain();
		if (sb.errors == 0 && sb.outstanding() == 0)
			$display("depth_hole_fill_3x3: match");
		else
			$display("depth_hole_fill_3x3: mismatch");
		$finish;
	end

endmodule

[sim.f]
sv/dhf_pkg.sv
sv/dhf_div.sv
sv/dhf_datapath.sv
sv/dhf_ctrl.sv
sv/depth_hole_fill_3x3.sv
tb/depth_hole_fill_3x3_tb.sv
